// ===== hw/rtl/msgpack_value_encoder_macros.svh =====
// ============================================================================
// MessagePack value encoder assertion macros
// Concurrent assertion wrappers, empty in synthesis builds.
// ============================================================================
`ifndef MSGPACK_VALUE_ENCODER_MACROS_SVH
`define MSGPACK_VALUE_ENCODER_MACROS_SVH

`ifndef SYNTHESIS

`define MVE_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define MVE_NEVER(label, clk, rst_n, expr, msg) \
    `MVE_ASSERT(label, clk, rst_n, !(expr), msg)

`else

`define MVE_ASSERT(label, clk, rst_n, prop, msg)

`define MVE_NEVER(label, clk, rst_n, expr, msg)

`endif

`endif

// ===== hw/rtl/mve_pkg.sv =====
// ============================================================================
// MessagePack value encoder package
// Operation codes, format bytes and the front-to-back command type.
// ============================================================================
package mve_pkg;

    localparam logic [2:0] OP_NIL     = 3'd0;
    localparam logic [2:0] OP_BOOL    = 3'd1;
    localparam logic [2:0] OP_INT     = 3'd2;
    localparam logic [2:0] OP_DOUBLE  = 3'd3;
    localparam logic [2:0] OP_BIN     = 3'd4;
    localparam logic [2:0] OP_ARRAY   = 3'd5;
    localparam logic [2:0] OP_PAYLOAD = 3'd6;

    localparam logic [7:0] FMT_NIL      = 8'hC0;
    localparam logic [7:0] FMT_FALSE    = 8'hC2;
    localparam logic [7:0] FMT_TRUE     = 8'hC3;
    localparam logic [7:0] FMT_BIN8     = 8'hC4;
    localparam logic [7:0] FMT_BIN16    = 8'hC5;
    localparam logic [7:0] FMT_BIN32    = 8'hC6;
    localparam logic [7:0] FMT_FLOAT64  = 8'hCB;
    localparam logic [7:0] FMT_UINT8    = 8'hCC;
    localparam logic [7:0] FMT_UINT16   = 8'hCD;
    localparam logic [7:0] FMT_UINT32   = 8'hCE;
    localparam logic [7:0] FMT_INT8     = 8'hD0;
    localparam logic [7:0] FMT_INT64    = 8'hD3;
    localparam logic [7:0] FMT_FIXARRAY = 8'h90;
    localparam logic [7:0] FMT_ARRAY16  = 8'hDC;
    localparam logic [7:0] FMT_ARRAY32  = 8'hDD;

    localparam logic [3:0] NB_0 = 4'd0;
    localparam logic [3:0] NB_1 = 4'd1;
    localparam logic [3:0] NB_2 = 4'd2;
    localparam logic [3:0] NB_4 = 4'd4;
    localparam logic [3:0] NB_8 = 4'd8;

    // tag byte, then nbytes bytes taken from the top of data
    typedef struct packed {
        logic [7:0]  tag;
        logic [63:0] data;
        logic [3:0]  nbytes;
    } t_cmd;

endpackage

// ===== hw/rtl/mve_cmd_fifo.sv =====
// ============================================================================
// MessagePack value encoder command queue
// Small register queue between the classifier and the byte serializer.
// ============================================================================
module mve_cmd_fifo #(
    parameter int DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  mve_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output mve_pkg::t_cmd o_cmd,
    output logic          o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    mve_pkg::t_cmd r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

`include "msgpack_value_encoder_macros.svh"

    `MVE_NEVER(a_fifo_overflow, i_clk, i_rst_n, i_push && o_full && !i_pop, "push into full queue")
    `MVE_NEVER(a_fifo_underflow, i_clk, i_rst_n, i_pop && o_empty, "pop from empty queue")

endmodule

// ===== hw/rtl/mve_classify.sv =====
// ============================================================================
// MessagePack value encoder classifier
// Accepts requests and picks the format byte and payload width for each.
// ============================================================================
module mve_classify (
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [2:0]    i_operation,
    input  logic [63:0]   i_value,
    input  logic [31:0]   i_length,
    input  logic [7:0]    i_data_byte,
    input  logic          i_full,
    output logic          o_push,
    output mve_pkg::t_cmd o_cmd
);

    logic        keep;
    logic [7:0]  tag;
    logic [3:0]  nbytes;
    logic [63:0] src;
    logic [63:0] len64;

    assign len64 = {32'd0, i_length};

    always_comb begin
        keep   = 1'b1;
        tag    = mve_pkg::FMT_NIL;
        nbytes = mve_pkg::NB_0;
        src    = i_value;
        unique case (i_operation)
            mve_pkg::OP_NIL: begin
                tag = mve_pkg::FMT_NIL;
            end
            mve_pkg::OP_BOOL: begin
                tag = i_value[0] ? mve_pkg::FMT_TRUE : mve_pkg::FMT_FALSE;
            end
            mve_pkg::OP_INT: begin
                if (!i_value[63]) begin
                    if (i_value[63:7] == '0) begin
                        tag = i_value[7:0];
                    end else if (i_value[63:8] == '0) begin
                        tag    = mve_pkg::FMT_UINT8;
                        nbytes = mve_pkg::NB_1;
                    end else if (i_value[63:16] == '0) begin
                        tag    = mve_pkg::FMT_UINT16;
                        nbytes = mve_pkg::NB_2;
                    end else if (i_value[63:32] == '0) begin
                        tag    = mve_pkg::FMT_UINT32;
                        nbytes = mve_pkg::NB_4;
                    end else begin
                        tag    = mve_pkg::FMT_INT64;
                        nbytes = mve_pkg::NB_8;
                    end
                end else begin
                    if (&i_value[63:5]) begin
                        tag = i_value[7:0];
                    end else if (&i_value[63:7]) begin
                        tag    = mve_pkg::FMT_INT8;
                        nbytes = mve_pkg::NB_1;
                    end else begin
                        tag    = mve_pkg::FMT_INT64;
                        nbytes = mve_pkg::NB_8;
                    end
                end
            end
            mve_pkg::OP_DOUBLE: begin
                tag    = mve_pkg::FMT_FLOAT64;
                nbytes = mve_pkg::NB_8;
            end
            mve_pkg::OP_BIN: begin
                src = len64;
                if (i_length[31:8] == '0) begin
                    tag    = mve_pkg::FMT_BIN8;
                    nbytes = mve_pkg::NB_1;
                end else if (i_length[31:16] == '0) begin
                    tag    = mve_pkg::FMT_BIN16;
                    nbytes = mve_pkg::NB_2;
                end else begin
                    tag    = mve_pkg::FMT_BIN32;
                    nbytes = mve_pkg::NB_4;
                end
            end
            mve_pkg::OP_ARRAY: begin
                src = len64;
                if (i_length[31:4] == '0) begin
                    tag = mve_pkg::FMT_FIXARRAY | {4'd0, i_length[3:0]};
                end else if (i_length[31:16] == '0) begin
                    tag    = mve_pkg::FMT_ARRAY16;
                    nbytes = mve_pkg::NB_2;
                end else begin
                    tag    = mve_pkg::FMT_ARRAY32;
                    nbytes = mve_pkg::NB_4;
                end
            end
            mve_pkg::OP_PAYLOAD: begin
                tag = i_data_byte;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    // left-align the payload so the serializer always takes the top byte
    always_comb begin
        o_cmd.tag    = tag;
        o_cmd.nbytes = nbytes;
        unique case (nbytes)
            mve_pkg::NB_1: o_cmd.data = {src[7:0], 56'd0};
            mve_pkg::NB_2: o_cmd.data = {src[15:0], 48'd0};
            mve_pkg::NB_4: o_cmd.data = {src[31:0], 32'd0};
            mve_pkg::NB_8: o_cmd.data = src;
            default:       o_cmd.data = '0;
        endcase
    end

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full && keep;

endmodule

// ===== hw/rtl/mve_serializer.sv =====
// ============================================================================
// MessagePack value encoder serializer
// Emits format byte and payload bytes, one per cycle while the output is ready, with a last mark.
// ============================================================================
module mve_serializer (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_empty,
    input  mve_pkg::t_cmd i_cmd,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [7:0]    o_byte,
    output logic          o_last
);

    logic        r_busy, n_busy;
    logic [3:0]  r_cnt, n_cnt;
    logic [63:0] r_shift, n_shift;
    logic        r_out_valid, n_out_valid;
    logic [7:0]  r_out_byte, n_out_byte;
    logic        r_out_last, n_out_last;
    logic        advance;

    assign advance = !r_out_valid || i_ready;

    always_comb begin
        n_busy      = r_busy;
        n_cnt       = r_cnt;
        n_shift     = r_shift;
        n_out_valid = r_out_valid;
        n_out_byte  = r_out_byte;
        n_out_last  = r_out_last;
        o_pop       = 1'b0;
        if (advance) begin
            if (r_busy) begin
                n_out_valid = 1'b1;
                n_out_byte  = r_shift[63:56];
                n_out_last  = (r_cnt == 4'd1);
                n_shift     = {r_shift[55:0], 8'd0};
                n_cnt       = r_cnt - 4'd1;
                n_busy      = (r_cnt != 4'd1);
            end else if (!i_empty) begin
                o_pop       = 1'b1;
                n_out_valid = 1'b1;
                n_out_byte  = i_cmd.tag;
                n_out_last  = (i_cmd.nbytes == mve_pkg::NB_0);
                n_shift     = i_cmd.data;
                n_cnt       = i_cmd.nbytes;
                n_busy      = (i_cmd.nbytes != mve_pkg::NB_0);
            end else begin
                n_out_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_shift    <= n_shift;
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
    end

    assign o_valid = r_out_valid;
    assign o_byte  = r_out_byte;
    assign o_last  = r_out_last;

`include "msgpack_value_encoder_macros.svh"

    `MVE_ASSERT(a_busy_has_bytes, i_clk, i_rst_n, r_busy |-> (r_cnt != 4'd0), "busy with no bytes left")
    `MVE_ASSERT(a_mid_item_busy, i_clk, i_rst_n, (r_out_valid && !r_out_last) |-> r_busy, "item ended without last")
    `MVE_NEVER(a_pop_while_busy, i_clk, i_rst_n, o_pop && r_busy, "new request taken mid item")

endmodule

// ===== hw/rtl/msgpack_value_encoder.sv =====
// ============================================================================
// MessagePack value encoder
// Encodes one value request into its MessagePack byte stream.
// ============================================================================
// Each accepted request yields 1 to 9 output bytes (format byte first, then
// the payload most significant byte first), the final one flagged by o_last;
// an unused operation code is accepted and yields nothing. The output runs
// at one byte per cycle while i_out_ready is high, and a request holds at
// most 9 bytes, for a 64-bit integer or a double. Requests are classified
// on entry and held in a QUEUE_DEPTH deep command queue, so input is taken
// every cycle while the queue has room, independent of output stalls.
module msgpack_value_encoder #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_operation,
    input  logic [63:0] i_value,
    input  logic [31:0] i_length,
    input  logic [7:0]  i_data_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_last
);

    mve_pkg::t_cmd push_cmd;
    mve_pkg::t_cmd head_cmd;
    logic          push;
    logic          pop;
    logic          full;
    logic          empty;

    mve_classify u_classify (
        .i_valid     (i_in_valid),
        .o_ready     (o_in_ready),
        .i_operation (i_operation),
        .i_value     (i_value),
        .i_length    (i_length),
        .i_data_byte (i_data_byte),
        .i_full      (full),
        .o_push      (push),
        .o_cmd       (push_cmd)
    );

    mve_cmd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_empty (empty)
    );

    mve_serializer u_serializer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_cmd   (head_cmd),
        .o_pop   (pop),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_byte  (o_out_byte),
        .o_last  (o_last)
    );

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// ============================================================================
// MessagePack value encoder testbench
// Sends nil, bool, integer, double, bin and array header, payload byte and
// unused-code requests through the encoder and checks every output byte and
// its last flag against an encoding worked out in the testbench itself.
// ============================================================================
module testbench;

    localparam logic [2:0] OP_UNUSED = 3'd7;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 48;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } t_stream_byte;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [2:0]  i_operation;
    logic [63:0] i_value;
    logic [31:0] i_length;
    logic [7:0]  i_data_byte;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [7:0]  o_out_byte;
    logic        o_last;

    t_stream_byte expected_stream[$];
    t_stream_byte item_bytes[$];
    int mismatch_count = 0;
    int idle_count = 0;
    int sink_hold = 0;
    bit src_gaps = 0;
    bit sink_stalls = 0;

    msgpack_value_encoder u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_operation (i_operation),
        .i_value     (i_value),
        .i_length    (i_length),
        .i_data_byte (i_data_byte),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_byte  (o_out_byte),
        .o_last      (o_last)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // ------------------------------------------------------------------------
    // expected encoding
    // ------------------------------------------------------------------------
    function automatic void put_byte(input logic [7:0] b);
        t_stream_byte sb;
        sb.data = b;
        sb.last = 1'b0;
        item_bytes.push_back(sb);
    endfunction

    function automatic void put_tagged(input logic [7:0] tag, input logic [63:0] val,
                                       input int nbytes);
        put_byte(tag);
        for (int i = nbytes - 1; i >= 0; i--) put_byte(val[i*8 +: 8]);
    endfunction

    function automatic void predict_encoding(input logic [2:0] op, input logic [63:0] value,
                                             input logic [31:0] length,
                                             input logic [7:0] data_byte);
        item_bytes.delete();
        case (op)
            mve_pkg::OP_NIL:  put_byte(mve_pkg::FMT_NIL);
            mve_pkg::OP_BOOL: put_byte(value[0] ? mve_pkg::FMT_TRUE : mve_pkg::FMT_FALSE);
            mve_pkg::OP_INT: begin
                if (!value[63]) begin
                    if (value <= 64'd127)            put_byte(value[7:0]);
                    else if (value <= 64'hFF)        put_tagged(mve_pkg::FMT_UINT8, value, 1);
                    else if (value <= 64'hFFFF)      put_tagged(mve_pkg::FMT_UINT16, value, 2);
                    else if (value <= 64'hFFFF_FFFF) put_tagged(mve_pkg::FMT_UINT32, value, 4);
                    else                             put_tagged(mve_pkg::FMT_INT64, value, 8);
                end else begin
                    if (value >= 64'hFFFF_FFFF_FFFF_FFE0)
                        put_byte(value[7:0]);
                    else if (value >= 64'hFFFF_FFFF_FFFF_FF80)
                        put_tagged(mve_pkg::FMT_INT8, value, 1);
                    else
                        put_tagged(mve_pkg::FMT_INT64, value, 8);
                end
            end
            mve_pkg::OP_DOUBLE: put_tagged(mve_pkg::FMT_FLOAT64, value, 8);
            mve_pkg::OP_BIN: begin
                if (length <= 32'hFF)
                    put_tagged(mve_pkg::FMT_BIN8, {32'd0, length}, 1);
                else if (length <= 32'hFFFF)
                    put_tagged(mve_pkg::FMT_BIN16, {32'd0, length}, 2);
                else
                    put_tagged(mve_pkg::FMT_BIN32, {32'd0, length}, 4);
            end
            mve_pkg::OP_ARRAY: begin
                if (length <= 32'd15)
                    put_byte(mve_pkg::FMT_FIXARRAY | length[7:0]);
                else if (length <= 32'hFFFF)
                    put_tagged(mve_pkg::FMT_ARRAY16, {32'd0, length}, 2);
                else
                    put_tagged(mve_pkg::FMT_ARRAY32, {32'd0, length}, 4);
            end
            mve_pkg::OP_PAYLOAD: put_byte(data_byte);
            default: ;
        endcase
        if (item_bytes.size() > 0) item_bytes[item_bytes.size() - 1].last = 1'b1;
        foreach (item_bytes[k]) expected_stream.push_back(item_bytes[k]);
    endfunction

    // ------------------------------------------------------------------------
    // random values
    // ------------------------------------------------------------------------
    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic int gap_len();
        if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // integers spread over every size class, edges included
    function automatic logic [63:0] rand_int_value();
        logic [63:0] v;
        int k;
        case ($urandom_range(0, 2))
            0: v = rand64();
            1: begin
                k = $urandom_range(1, 64);
                v = rand64() >> (64 - k);
                if ($urandom_range(0, 1)) v = -v;
            end
            default: begin
                case ($urandom_range(0, 7))
                    0: v = 64'd0;
                    1: v = 64'd127;
                    2: v = 64'hFF;
                    3: v = 64'hFFFF;
                    4: v = 64'hFFFF_FFFF;
                    5: v = -64'd32;
                    6: v = -64'd128;
                    default: v = 64'h7FFF_FFFF_FFFF_FFFF;
                endcase
                v = v + 64'($urandom_range(0, 2)) - 64'd1;
            end
        endcase
        return v;
    endfunction

    function automatic logic [31:0] rand_length();
        logic [31:0] n;
        int k;
        case ($urandom_range(0, 2))
            0: n = $urandom;
            1: begin
                k = $urandom_range(1, 32);
                n = $urandom >> (32 - k);
            end
            default: begin
                case ($urandom_range(0, 4))
                    0: n = 32'd15;
                    1: n = 32'hFF;
                    2: n = 32'hFFFF;
                    3: n = 32'd0;
                    default: n = 32'hFFFF_FFFF;
                endcase
                n = n + 32'($urandom_range(0, 2)) - 32'd1;
            end
        endcase
        return n;
    endfunction

    // ------------------------------------------------------------------------
    // request driver
    // ------------------------------------------------------------------------
    task automatic send_request(input logic [2:0] op, input logic [63:0] value,
                                input logic [31:0] length, input logic [7:0] data_byte);
        int gap;
        gap = (src_gaps && $urandom_range(0, 1)) ? gap_len() : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_operation <= op;
        i_value     <= value;
        i_length    <= length;
        i_data_byte <= data_byte;
        predict_encoding(op, value, length, data_byte);
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic send_random_item(input logic [2:0] op);
        send_request(op, (op == mve_pkg::OP_INT) ? rand_int_value() : rand64(), rand_length(),
                     8'($urandom));
    endtask

    function automatic logic [2:0] rand_op();
        if ($urandom_range(0, 99) < 4) return OP_UNUSED;
        return 3'($urandom_range(0, 6));
    endfunction

    function automatic logic [2:0] rand_scalar_op();
        case ($urandom_range(0, 3))
            0: return mve_pkg::OP_NIL;
            1: return mve_pkg::OP_BOOL;
            2: return mve_pkg::OP_INT;
            default: return mve_pkg::OP_DOUBLE;
        endcase
    endfunction

    task automatic pause_until_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_stream.size() != 0) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // result sink and checker
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!sink_stalls) begin
            i_out_ready <= 1'b1;
            sink_hold = 0;
        end else if (sink_hold > 0) begin
            i_out_ready <= 1'b0;
            sink_hold--;
        end else if ($urandom_range(0, 3) == 0) begin
            i_out_ready <= 1'b0;
            sink_hold = gap_len() - 1;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH at %0t: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin
        t_stream_byte want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_stream.size() == 0) begin
                report_mismatch("output byte with nothing pending", 64'(o_out_byte), 64'd0);
            end else begin
                want = expected_stream.pop_front();
                if (o_out_byte !== want.data)
                    report_mismatch("out_byte", 64'(o_out_byte), 64'(want.data));
                if (o_last !== want.last)
                    report_mismatch("last", 64'(o_last), 64'(want.last));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            idle_count = 0;
        else
            idle_count++;
        if (idle_count >= WATCHDOG_LIMIT) begin
            $display("TIMEOUT at %0t: no request or byte moved for %0d cycles",
                     $time, WATCHDOG_LIMIT);
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_directed();
        src_gaps = 0;
        sink_stalls = 0;
        send_request(mve_pkg::OP_NIL, rand64(), $urandom, 8'($urandom));
        send_request(mve_pkg::OP_BOOL, 64'd1, $urandom, 8'($urandom));
        send_request(mve_pkg::OP_BOOL, 64'hFFFF_FFFF_FFFF_FFFE, $urandom, 8'($urandom));
        send_request(mve_pkg::OP_INT, 64'd0, $urandom, 8'($urandom));
        send_request(mve_pkg::OP_INT, 64'd127, $urandom, 8'($urandom));
        send_request(mve_pkg::OP_INT, 64'd128, $urandom, 8'($urandom));
        send_request(mve_pkg::OP_INT, 64'd256, $urandom, 8'($urandom));
        send_request(mve_pkg::OP_INT, 64'hFFFF, $urandom, 8'($urandom));
        send_request(mve_pkg::OP_INT, 64'h1_0000, $urandom, 8'($urandom));
        send_request(mve_pkg::OP_INT, 64'hFFFF_FFFF, $urandom, 8'($urandom));
        send_request(mve_pkg::OP_INT, 64'h1_0000_0000, $urandom, 8'($urandom));
        send_request(mve_pkg::OP_INT, 64'h7FFF_FFFF_FFFF_FFFF, $urandom, 8'($urandom));
        send_request(mve_pkg::OP_INT, -64'd32, $urandom, 8'($urandom));
        send_request(mve_pkg::OP_INT, -64'd33, $urandom, 8'($urandom));
        send_request(mve_pkg::OP_INT, -64'd128, $urandom, 8'($urandom));
        send_request(mve_pkg::OP_INT, -64'd129, $urandom, 8'($urandom));
        send_request(mve_pkg::OP_INT, 64'h8000_0000_0000_0000, $urandom, 8'($urandom));
        send_request(mve_pkg::OP_DOUBLE, 64'hFFF0_0000_0000_0001, $urandom, 8'($urandom));
        send_request(mve_pkg::OP_BIN, rand64(), 32'hFF, 8'($urandom));
        send_request(mve_pkg::OP_BIN, rand64(), 32'h100, 8'($urandom));
        send_request(mve_pkg::OP_BIN, rand64(), 32'hFFFF_FFFF, 8'($urandom));
        send_request(mve_pkg::OP_ARRAY, rand64(), 32'd15, 8'($urandom));
        send_request(mve_pkg::OP_ARRAY, rand64(), 32'd16, 8'($urandom));
        send_request(mve_pkg::OP_ARRAY, rand64(), 32'h1_0000, 8'($urandom));
        send_request(mve_pkg::OP_PAYLOAD, rand64(), $urandom, 8'hFF);
        send_request(OP_UNUSED, rand64(), $urandom, 8'($urandom));
    endtask

    task automatic test_random_mix();
        src_gaps = 1;
        sink_stalls = 1;
        repeat (230) send_random_item(rand_op());
    endtask

    // bin headers followed by their payload, arrays followed by their elements
    task automatic test_framed_sequences();
        int count;
        src_gaps = 1;
        sink_stalls = $urandom_range(0, 1);
        pause_until_drained();
        repeat (28) begin
            count = $urandom_range(0, 6);
            if ($urandom_range(0, 1)) begin
                send_request(mve_pkg::OP_BIN, rand64(), 32'(count), 8'($urandom));
                repeat (count) send_random_item(mve_pkg::OP_PAYLOAD);
            end else begin
                send_request(mve_pkg::OP_ARRAY, rand64(), 32'(count), 8'($urandom));
                repeat (count) send_random_item(rand_scalar_op());
            end
            if ($urandom_range(0, 7) == 0) send_random_item(rand_op());
        end
    endtask

    task automatic test_output_backpressure();
        src_gaps = 0;
        sink_stalls = 1;
        pause_until_drained();
        repeat (60) send_random_item(rand_op());
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_operation = mve_pkg::OP_NIL;
        i_value     = '0;
        i_length    = '0;
        i_data_byte = '0;
        i_out_ready = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_random_mix();
        test_framed_sequences();
        test_output_backpressure();

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_stream.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== msgpack_value_encoder.f =====
+incdir+hw/rtl
hw/rtl/mve_pkg.sv
hw/rtl/mve_cmd_fifo.sv
hw/rtl/mve_classify.sv
hw/rtl/mve_serializer.sv
hw/rtl/msgpack_value_encoder.sv
test/testbench.sv
